### rtl/ctb_pkg.sv
package ctb_pkg;

  // Bank geometry
  localparam int unsigned NumTimers = 16;
  localparam int unsigned AddrW     = $clog2(NumTimers);
  localparam int unsigned CntW      = $clog2(NumTimers + 1);
  localparam int unsigned IdxW      = 4;
  localparam int unsigned ValW      = 32;

  localparam logic [ValW-1:0] LockedValue = '1;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_SET   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_LOCK  = 3'd4,
    CMD_DELAY = 3'd5
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TICK,
    ST_EMIT
  } state_e;

  // Timer memory access, controller to RAM
  typedef struct packed {
    logic            we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic            re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic [IdxW-1:0] alloc_idx;
    logic [ValW-1:0] read_value;
    logic            ok;
    logic [ValW-1:0] delay;
  } result_t;

endpackage

### rtl/countdown_timer_bank.sv
// Countdown timer bank with one delay counter.
//
// Commands arrive on the s_axis channel, one transfer per command: tuser
// carries the command code (tick, allocate, set, read, lock, start delay),
// tdata the timer index and a duration. Every command yields exactly one
// result transfer on m_axis: allocated index, read value, ok flag and the
// delay counter as it stands after the command.
//
// Sequence, accept to result valid: allocate, set, lock, start delay and
// unknown codes go to ST_EMIT, read passes ST_READ first (one memory read).
// A tick walks all allocated timers through the timer memory in ST_TICK,
// one entry per cycle with read and write-back overlapped, then goes on to
// ST_EMIT. The next command is taken right after the result has moved into
// the output register.
//
// Reset clears the allocation count and the delay counter; the timer memory
// is not cleared, each entry is written when its timer is allocated. When
// the receiver stalls, the result waits in the output register; one more
// command is still accepted and processed, then s_axis_tready stays low.
module countdown_timer_bank_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // timer_index[3:0], duration[35:4], zero[39:36]
  input  logic [2:0]   s_axis_tuser,   // cmd[2:0]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // allocated_index[3:0], read_value[35:4], ok[36],
                                       // delay_remaining[68:37], zero[71:69]
);

  ctb_pkg::mem_req_t            mem_req;
  logic [ctb_pkg::ValW-1:0]     mem_rdata;
  ctb_pkg::result_t             res;
  logic                         res_valid;
  logic                         out_free;
  logic                         out_valid_q;
  ctb_pkg::result_t             out_q;

  assign out_free = !out_valid_q || m_axis_tready;

  ctb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (ctb_pkg::cmd_e'(s_axis_tuser)),
    .idx_i       (s_axis_tdata[3:0]),
    .dur_i       (s_axis_tdata[35:4]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  ctb_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.delay, out_q.ok, out_q.read_value, out_q.alloc_idx};

endmodule

### rtl/ctb_ram.sv
module ctb_ram (
  input  logic                        clk_i,
  input  ctb_pkg::mem_req_t           req_i,
  output logic [ctb_pkg::ValW-1:0]    rdata_o
);

  logic [ctb_pkg::ValW-1:0] mem [ctb_pkg::NumTimers];
  logic [ctb_pkg::ValW-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ctb_ctrl.sv
module ctb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command transfer
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ctb_pkg::cmd_e                 cmd_i,
  input  logic [ctb_pkg::IdxW-1:0]      idx_i,
  input  logic [ctb_pkg::ValW-1:0]      dur_i,
  // result hand-off to the output register
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output ctb_pkg::result_t              res_o,
  // timer memory
  output ctb_pkg::mem_req_t             mem_req_o,
  input  logic [ctb_pkg::ValW-1:0]      mem_rdata_i
);

  ctb_pkg::state_e              state_q, state_d;
  ctb_pkg::result_t             res_q, res_d;
  logic [ctb_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [ctb_pkg::ValW-1:0]     delay_q, delay_d;
  logic [ctb_pkg::CntW-1:0]     ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [ctb_pkg::AddrW-1:0]    waddr_q, waddr_d;

  logic                         accept;
  logic                         hit;
  logic                         can_alloc;
  logic                         issue;
  logic [ctb_pkg::ValW-1:0]     dec_val;

  assign accept    = in_valid_i && (state_q == ctb_pkg::ST_IDLE);
  assign hit       = {{(ctb_pkg::CntW - ctb_pkg::IdxW){1'b0}}, idx_i} < cnt_q;
  assign can_alloc = cnt_q < ctb_pkg::CntW'(ctb_pkg::NumTimers);
  assign issue     = ptr_q < cnt_q;

  // Tick update of one timer: hold at zero and at the locked value
  assign dec_val = ((mem_rdata_i == '0) || (mem_rdata_i == ctb_pkg::LockedValue)) ?
                   mem_rdata_i : mem_rdata_i - 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == ctb_pkg::CMD_READ) begin
            state_d = ctb_pkg::ST_READ;
          end else if (cmd_i == ctb_pkg::CMD_TICK) begin
            state_d = ctb_pkg::ST_TICK;
          end else begin
            state_d = ctb_pkg::ST_EMIT;
          end
        end
      end
      ctb_pkg::ST_READ: state_d = ctb_pkg::ST_EMIT;
      ctb_pkg::ST_TICK: begin
        if (!issue && !pend_q) begin
          state_d = ctb_pkg::ST_EMIT;
        end
      end
      ctb_pkg::ST_EMIT: begin
        if (out_free_i) begin
          state_d = ctb_pkg::ST_IDLE;
        end
      end
      default: state_d = ctb_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory accesses
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o   = '0;
    case (state_q)
      ctb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_i)
            ctb_pkg::CMD_ALLOC: begin
              mem_req_o.we    = can_alloc;
              mem_req_o.waddr = cnt_q[ctb_pkg::AddrW-1:0];
              mem_req_o.wdata = ctb_pkg::LockedValue;
            end
            ctb_pkg::CMD_SET: begin
              mem_req_o.we    = hit;
              mem_req_o.waddr = idx_i[ctb_pkg::AddrW-1:0];
              mem_req_o.wdata = dur_i;
            end
            ctb_pkg::CMD_LOCK: begin
              mem_req_o.we    = hit;
              mem_req_o.waddr = idx_i[ctb_pkg::AddrW-1:0];
              mem_req_o.wdata = ctb_pkg::LockedValue;
            end
            ctb_pkg::CMD_READ: begin
              mem_req_o.re    = hit;
              mem_req_o.raddr = idx_i[ctb_pkg::AddrW-1:0];
            end
            default: ;
          endcase
        end
      end
      ctb_pkg::ST_TICK: begin
        // read entry ptr while writing back the entry read last cycle
        mem_req_o.re    = issue;
        mem_req_o.raddr = ptr_q[ctb_pkg::AddrW-1:0];
        mem_req_o.we    = pend_q;
        mem_req_o.waddr = waddr_q;
        mem_req_o.wdata = dec_val;
      end
      ctb_pkg::ST_EMIT: res_valid_o = out_free_i;
      default: ;
    endcase
  end

  // Datapath: counters, delay and result
  always_comb begin
    res_d   = res_q;
    cnt_d   = cnt_q;
    delay_d = delay_q;
    ptr_d   = ptr_q;
    pend_d  = 1'b0;
    waddr_d = waddr_q;
    if (accept) begin
      res_d       = '0;
      res_d.delay = delay_q;
      ptr_d       = '0;
      case (cmd_i)
        ctb_pkg::CMD_TICK: begin
          if (delay_q != '0) begin
            delay_d = delay_q - 1'b1;
          end
          res_d.delay = delay_d;
        end
        ctb_pkg::CMD_ALLOC: begin
          if (can_alloc) begin
            res_d.alloc_idx = cnt_q[ctb_pkg::IdxW-1:0];
            res_d.ok        = 1'b1;
            cnt_d           = cnt_q + 1'b1;
          end
        end
        ctb_pkg::CMD_SET:  res_d.ok = hit;
        ctb_pkg::CMD_LOCK: res_d.ok = hit;
        ctb_pkg::CMD_READ: begin
          res_d.ok         = hit;
          res_d.read_value = ctb_pkg::LockedValue;
        end
        ctb_pkg::CMD_DELAY: begin
          delay_d     = dur_i;
          res_d.delay = dur_i;
        end
        default: ;
      endcase
    end else if (state_q == ctb_pkg::ST_READ) begin
      if (res_q.ok) begin
        res_d.read_value = mem_rdata_i;
      end
    end else if (state_q == ctb_pkg::ST_TICK) begin
      if (issue) begin
        ptr_d = ptr_q + 1'b1;
      end
      pend_d  = issue;
      waddr_d = ptr_q[ctb_pkg::AddrW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctb_pkg::ST_IDLE;
      cnt_q   <= '0;
      delay_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      delay_q <= delay_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    ptr_q   <= ptr_d;
    waddr_q <= waddr_d;
  end

  assign res_o = res_q;

  // Allocation never runs past the bank
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ctb_pkg::CntW'(ctb_pkg::NumTimers))
    else $error("allocated count beyond bank size");

  // Tick walk pointer never passes the allocated count
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctb_pkg::ST_TICK) |-> (ptr_q <= cnt_q))
    else $error("tick walk pointer past allocated count");

  // Write-back and read of the walk never hit the same entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("read and write to the same timer entry");

  // A result is only handed off when the output register can take it
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (out_free_i && (state_q == ctb_pkg::ST_EMIT)))
    else $error("result handed off without room");

  // One command at a time: no acceptance right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second command accepted while busy");

endmodule
